>>> rtl/psb_pkg.sv
// psb_pkg: shared constants and types for the positional sequence buffer
// depends on nothing; imported by every module of the block

package psb_pkg;

  // storage size and derived widths
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed port field widths
  localparam int CMD_W   = 2;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 5;

  // operation codes
  localparam logic [CMD_W-1:0] OP_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] OP_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] OP_READ   = 2'd2;
  localparam logic [CMD_W-1:0] OP_REMOVE = 2'd3;

  // controller commands to the datapath
  typedef struct packed {
    logic load;  // capture the request word
    logic exec;  // perform the captured request
  } psb_cmd_t;

endpackage

>>> rtl/psb_ctrl.sv
// psb_ctrl: controller state machine, sequences capture and execute of one request
// depends on psb_pkg

module psb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output psb_pkg::psb_cmd_t cmd_o
);
  import psb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands and handshake
  assign busy       = (state == ST_EXEC);
  assign cmd_o.load = (state == ST_IDLE) && start;
  assign cmd_o.exec = (state == ST_EXEC);

endmodule

>>> rtl/psb_datapath.sv
// psb_datapath: request registers, entry shift chain, count and result registers
// depends on psb_pkg

module psb_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  psb_pkg::psb_cmd_t            cmd_i,
  input  logic [psb_pkg::CMD_W-1:0]    cmd,
  input  logic [psb_pkg::POS_W-1:0]    position,
  input  logic [psb_pkg::VALUE_W-1:0]  value,
  output logic                         done,
  output logic [psb_pkg::VALUE_W-1:0]  data_out,
  output logic                         ok,
  output logic [psb_pkg::LEN_W-1:0]    length
);
  import psb_pkg::*;

  logic [CMD_W-1:0]      req_cmd;
  logic [POS_W-1:0]      req_pos;
  logic [DATA_WIDTH-1:0] req_val;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  logic                  is_add;
  logic                  is_remove;
  logic [POS_W:0]        pos_x;
  logic [POS_W:0]        cnt_x;
  logic [CNT_W-1:0]      ins_pos;
  logic                  req_ok;
  logic [DATA_WIDTH-1:0] rd_word;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_cmd <= cmd;
      req_pos <= position;
      req_val <= value[DATA_WIDTH-1:0];
    end
  end

  // request decode and range checks
  always_comb begin
    pos_x     = {1'b0, req_pos};
    cnt_x     = (POS_W + 1)'(count);
    is_add    = (req_cmd == OP_APPEND) || (req_cmd == OP_INSERT);
    is_remove = (req_cmd == OP_REMOVE);
    ins_pos   = (req_cmd == OP_APPEND) ? count : CNT_W'(req_pos);
    unique case (req_cmd)
      OP_APPEND: req_ok = (count < CNT_W'(CAPACITY));
      OP_INSERT: req_ok = (pos_x <= cnt_x) && (count < CNT_W'(CAPACITY));
      OP_READ:   req_ok = (pos_x < cnt_x);
      OP_REMOVE: req_ok = (pos_x < cnt_x);
      default:   req_ok = 1'b0;
    endcase
  end

  // word at the requested position, valid only when in range
  assign rd_word = entries[req_pos[IDX_W-1:0]];

  // count update
  always_comb begin
    count_next = count;
    if (req_ok && is_add) begin
      count_next = count + CNT_W'(1);
    end else if (req_ok && is_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd_i.exec) begin
      count <= count_next;
    end
  end

  // shift chain: each entry keeps its word, takes the request value, or takes its lower or its upper neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd_i.exec && req_ok) begin
          if (is_add && (ins_pos == CNT_W'(i))) begin
            entries[i] <= req_val;
          end else if (is_remove && (CNT_W'(i) >= CNT_W'(req_pos))
                       && (CNT_W'(i + 1) < count)) begin
            entries[i] <= entries[i + 1];
          end
        end
      end
    end else if (i == CAPACITY - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd_i.exec && req_ok && is_add) begin
          if (ins_pos == CNT_W'(i)) begin
            entries[i] <= req_val;
          end else if ((CNT_W'(i) > ins_pos) && (CNT_W'(i) <= count)) begin
            entries[i] <= entries[i - 1];
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd_i.exec && req_ok) begin
          if (is_add && (ins_pos == CNT_W'(i))) begin
            entries[i] <= req_val;
          end else if (is_add && (CNT_W'(i) > ins_pos) && (CNT_W'(i) <= count)) begin
            entries[i] <= entries[i - 1];
          end else if (is_remove && (CNT_W'(i) >= CNT_W'(req_pos))
                       && (CNT_W'(i + 1) < count)) begin
            entries[i] <= entries[i + 1];
          end
        end
      end
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      ok       <= req_ok;
      length   <= LEN_W'(count_next);
      data_out <= (req_ok && !is_add) ? VALUE_W'(rd_word) : '0;
    end
  end

endmodule

>>> rtl/positional_sequence_buffer_unit.sv
// positional_sequence_buffer_unit: top level of the positional sequence buffer
// depends on psb_pkg, psb_ctrl and psb_datapath

// A request word (cmd, position, value) is taken at a clock edge where start is
// high and busy is low. The block then executes it in the register shift chain,
// with busy high, and takes no new request before it is through with this one.
// The result word appears on data_out, ok and length for exactly one
// cycle, marked by done, in the cycle after the execute cycle; the receiver must
// take it then, it cannot hold results off. Append and insert on a full store
// and any position out of range return ok low, data_out zero and leave the
// store as it was; length always reports the entry count after the request.

module positional_sequence_buffer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [psb_pkg::CMD_W-1:0]    cmd,
  input  logic [psb_pkg::POS_W-1:0]    position,
  input  logic [psb_pkg::VALUE_W-1:0]  value,
  output logic                         done,
  output logic [psb_pkg::VALUE_W-1:0]  data_out,
  output logic                         ok,
  output logic [psb_pkg::LEN_W-1:0]    length
);
  import psb_pkg::*;

  psb_cmd_t ctrl_cmd;

  // controller
  psb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd_o (ctrl_cmd)
  );

  // datapath
  psb_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd_i    (ctrl_cmd),
    .cmd      (cmd),
    .position (position),
    .value    (value),
    .done     (done),
    .data_out (data_out),
    .ok       (ok),
    .length   (length)
  );

endmodule
